// ----- rtl/core/msc_pkg.sv -----
package msc_pkg;

	// Store depths (powers of two)
	localparam int IMEM_WORDS_DEF = 256;
	localparam int DMEM_WORDS_DEF = 256;

	localparam int XLEN    = 32;
	localparam int RF_REGS = 32;
	localparam int RF_AW   = 5;

	// Item kinds carried on the input tuser
	localparam logic [1:0] OP_EXEC = 2'd0;
	localparam logic [1:0] OP_LDI  = 2'd1;
	localparam logic [1:0] OP_LDD  = 2'd2;

	// Primary opcodes
	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_BNE   = 6'h05;
	localparam logic [5:0] OPC_ADDI  = 6'h08;
	localparam logic [5:0] OPC_ADDIU = 6'h09;
	localparam logic [5:0] OPC_SLTI  = 6'h0a;
	localparam logic [5:0] OPC_ANDI  = 6'h0c;
	localparam logic [5:0] OPC_ORI   = 6'h0d;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_SW    = 6'h2b;

	// R-type function codes
	localparam logic [5:0] FN_ADD  = 6'd32;
	localparam logic [5:0] FN_ADDU = 6'd33;
	localparam logic [5:0] FN_SUB  = 6'd34;
	localparam logic [5:0] FN_SUBU = 6'd35;
	localparam logic [5:0] FN_AND  = 6'd36;
	localparam logic [5:0] FN_OR   = 6'd37;
	localparam logic [5:0] FN_SLT  = 6'd42;

	// Decoded and executed instruction
	typedef struct packed {
		logic             valid;
		logic             wreg;     // register write, destination nonzero
		logic [RF_AW-1:0] dst;
		logic [XLEN-1:0]  value;    // ALU result (not used for lw)
		logic             is_lw;
		logic             wmem;
		logic [XLEN-1:0]  addr;     // rs + sign-extended offset
		logic [XLEN-1:0]  next_pc;
	} exec_t;

	// One register file write port
	typedef struct packed {
		logic             en;
		logic [RF_AW-1:0] addr;
		logic [XLEN-1:0]  data;
	} rf_wr_t;

endpackage

// ----- rtl/core/msc_ram.sv -----
module msc_ram #(
	parameter int WORDS = 256,
	localparam int AW = $clog2(WORDS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [WORDS];
	logic [31:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, new data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && waddr == raddr) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/msc_regfile.sv -----
module msc_regfile
	import msc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  rf_wr_t           wb,       // late write from a load word
	input  rf_wr_t           wr,       // write from the executing instruction
	input  logic [RF_AW-1:0] ra_addr,
	input  logic [RF_AW-1:0] rb_addr,
	output logic [XLEN-1:0]  ra_data,
	output logic [XLEN-1:0]  rb_data
);

	logic [XLEN-1:0] rf_q [RF_REGS];

	// Update registers; the executing instruction wins over the load write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RF_REGS; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < RF_REGS; i++) begin
				if (wr.en && wr.addr == RF_AW'(i)) begin
					rf_q[i] <= wr.data;
				end else if (wb.en && wb.addr == RF_AW'(i)) begin
					rf_q[i] <= wb.data;
				end
			end
		end
	end

	assign ra_data = rf_q[ra_addr];
	assign rb_data = rf_q[rb_addr];

endmodule

// ----- rtl/core/msc_exec.sv -----
module msc_exec
	import msc_pkg::*;
(
	input  logic [XLEN-1:0] pc,
	input  logic [31:0]     instr,
	input  logic [XLEN-1:0] a,
	input  logic [XLEN-1:0] b,
	output exec_t           ex
);

	logic [5:0]      opc;
	logic [5:0]      funct;
	logic [4:0]      rt;
	logic [4:0]      rd;
	logic [XLEN-1:0] simm;
	logic [XLEN-1:0] zimm;
	logic [XLEN-1:0] pc4;
	logic [XLEN-1:0] br_target;

	assign opc       = instr[31:26];
	assign rt        = instr[20:16];
	assign rd        = instr[15:11];
	assign funct     = instr[5:0];
	assign simm      = {{16{instr[15]}}, instr[15:0]};
	assign zimm      = {16'd0, instr[15:0]};
	assign pc4       = pc + 32'd4;
	assign br_target = pc4 + {simm[29:0], 2'b00};

	// Decode and execute
	always_comb begin
		ex         = '0;
		ex.valid   = 1'b1;
		ex.next_pc = pc4;
		ex.addr    = a + simm;
		case (opc)
			OPC_RTYPE: begin
				ex.dst  = rd;
				ex.wreg = 1'b1;
				case (funct)
					FN_ADD, FN_ADDU: ex.value = a + b;
					FN_SUB, FN_SUBU: ex.value = a - b;
					FN_AND:          ex.value = a & b;
					FN_OR:           ex.value = a | b;
					FN_SLT:          ex.value = {31'd0, a < b};
					default: begin
						ex.valid = 1'b0;
						ex.wreg  = 1'b0;
					end
				endcase
			end
			OPC_ADDI, OPC_ADDIU: begin
				ex.dst   = rt;
				ex.wreg  = 1'b1;
				ex.value = a + simm;
			end
			OPC_SLTI: begin
				ex.dst   = rt;
				ex.wreg  = 1'b1;
				ex.value = {31'd0, a < simm};
			end
			OPC_ANDI: begin
				ex.dst   = rt;
				ex.wreg  = 1'b1;
				ex.value = a & zimm;
			end
			OPC_ORI: begin
				ex.dst   = rt;
				ex.wreg  = 1'b1;
				ex.value = a | zimm;
			end
			OPC_LW: begin
				ex.dst   = rt;
				ex.wreg  = 1'b1;
				ex.is_lw = 1'b1;
			end
			OPC_SW: begin
				ex.wmem = 1'b1;
			end
			OPC_BEQ: begin
				if (a == b) begin
					ex.next_pc = br_target;
				end
			end
			OPC_BNE: begin
				if (a != b) begin
					ex.next_pc = br_target;
				end
			end
			OPC_J: begin
				ex.next_pc = {pc4[31:28], instr[25:0], 2'b00};
			end
			default: begin
				ex.valid = 1'b0;
			end
		endcase

		// Drop writes to register zero; an invalid encoding changes nothing
		if (ex.dst == '0) begin
			ex.wreg  = 1'b0;
			ex.is_lw = 1'b0;
		end
		if (!ex.valid) begin
			ex.next_pc = pc;
			ex.wmem    = 1'b0;
		end
		if (!ex.wreg) begin
			ex.dst   = '0;
			ex.value = '0;
		end
	end

endmodule

// ----- rtl/core/mips_single_cycle_core_unit.sv -----
// Channel  Dir  Payload (lowest bit first)
// s_axis   in   tuser: op[1:0]; tdata: word_index[7:0], load_word[39:8]
// m_axis   out  tdata: executed_pc, next_pc, invalid_instr, reg_write_en,
//               reg_number, reg_value, mem_write_en, mem_word_addr, mem_value
//
// One item per cycle while the output is not stalled: an execute item is
// fetched, decoded and run from the input register into the output register;
// loads give no result. A load word reaches its register through the data
// store's registered read; the following instruction takes it by forwarding.
// After reset both stores are cleared, one word per cycle, over all
// max(IMEM_WORDS, DMEM_WORDS) addresses while s_tready stays low.
// A stalled result holds; loads move on; one execute item waits at the input.
// Store depths are powers of two.
module mips_single_cycle_core_unit
	import msc_pkg::*;
#(
	parameter int IMEM_WORDS = IMEM_WORDS_DEF,
	parameter int DMEM_WORDS = DMEM_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,   // op
	input  logic [39:0]  s_tdata,   // word_index[7:0], load_word[39:8]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata    // executed_pc[31:0], next_pc[63:32],
	                                // invalid_instr[64], reg_write_en[65],
	                                // reg_number[70:66], reg_value[102:71],
	                                // mem_write_en[103], mem_word_addr[111:104],
	                                // mem_value[143:112]
);

	localparam int IAW  = $clog2(IMEM_WORDS);
	localparam int DAW  = $clog2(DMEM_WORDS);
	localparam int MAXW = (IMEM_WORDS > DMEM_WORDS) ? IMEM_WORDS : DMEM_WORDS;
	localparam int CW   = $clog2(MAXW);

	// Clearing pass
	logic          clr_busy_q;
	logic [CW-1:0] clr_cnt_q;

	// Input stage
	logic            v_s1;
	logic [1:0]      op_s1;
	logic [7:0]      idx_s1;
	logic [31:0]     word_s1;

	// Output stage
	logic            v_s2;
	logic [31:0]     epc_s2;
	logic [31:0]     npc_s2;
	logic            inv_s2;
	logic            rwe_s2;
	logic [4:0]      rnum_s2;
	logic [31:0]     rval_s2;
	logic            lw_s2;
	logic            mwe_s2;
	logic [7:0]      maddr_s2;
	logic [31:0]     mval_s2;

	logic            lw_pend_q;
	logic [31:0]     pc_q;

	logic            out_free;
	logic            s1_move;
	logic            exec_fire;
	logic            ldi_fire;
	logic            ldd_fire;

	logic [31:0]     instr;
	logic [31:0]     dmem_rdata;
	logic [31:0]     rf_a;
	logic [31:0]     rf_b;
	logic [31:0]     a;
	logic [31:0]     b;
	exec_t           ex;
	rf_wr_t          rf_wb;
	rf_wr_t          rf_wr;

	logic            imem_we;
	logic [IAW-1:0]  imem_waddr;
	logic [31:0]     imem_wdata;
	logic [IAW-1:0]  imem_raddr;
	logic            dmem_we;
	logic [DAW-1:0]  dmem_waddr;
	logic [31:0]     dmem_wdata;
	logic [DAW-1:0]  dmem_raddr;
	logic [DAW-1:0]  ex_daddr;

	// Handshake and stage movement
	assign out_free  = !v_s2 || m_tready;
	assign exec_fire = v_s1 && op_s1 == OP_EXEC && out_free;
	assign s1_move   = v_s1 && (op_s1 != OP_EXEC || out_free);
	assign ldi_fire  = s1_move && op_s1 == OP_LDI;
	assign ldd_fire  = s1_move && op_s1 == OP_LDD;
	assign s_tready  = !clr_busy_q && (!v_s1 || s1_move);

	// Sweep both stores to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CW'(MAXW - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Capture input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			idx_s1  <= s_tdata[7:0];
			word_s1 <= s_tdata[39:8];
		end
	end

	// Instruction store: keep the word at the coming PC in the read register
	assign imem_we    = clr_busy_q || ldi_fire;
	assign imem_waddr = clr_busy_q ? IAW'(clr_cnt_q) : IAW'(32'(idx_s1));
	assign imem_wdata = clr_busy_q ? 32'd0 : word_s1;
	assign imem_raddr = exec_fire ? IAW'(ex.next_pc >> 2) : IAW'(pc_q >> 2);

	msc_ram #(
		.WORDS (IMEM_WORDS)
	) u_imem (
		.clk   (clk),
		.we    (imem_we),
		.waddr (imem_waddr),
		.wdata (imem_wdata),
		.re    (1'b1),
		.raddr (imem_raddr),
		.rdata (instr)
	);

	// Register file with forwarding of the pending load word
	msc_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wb      (rf_wb),
		.wr      (rf_wr),
		.ra_addr (instr[25:21]),
		.rb_addr (instr[20:16]),
		.ra_data (rf_a),
		.rb_data (rf_b)
	);

	assign a = (lw_pend_q && rnum_s2 == instr[25:21]) ? dmem_rdata : rf_a;
	assign b = (lw_pend_q && rnum_s2 == instr[20:16]) ? dmem_rdata : rf_b;

	msc_exec u_exec (
		.pc    (pc_q),
		.instr (instr),
		.a     (a),
		.b     (b),
		.ex    (ex)
	);

	assign rf_wr.en   = exec_fire && ex.wreg && !ex.is_lw;
	assign rf_wr.addr = ex.dst;
	assign rf_wr.data = ex.value;
	assign rf_wb.en   = lw_pend_q;
	assign rf_wb.addr = rnum_s2;
	assign rf_wb.data = dmem_rdata;

	// Data store
	assign ex_daddr   = DAW'(ex.addr >> 2);
	assign dmem_we    = clr_busy_q || ldd_fire || (exec_fire && ex.wmem);
	assign dmem_waddr = clr_busy_q ? DAW'(clr_cnt_q) :
	                    ldd_fire ? DAW'(32'(idx_s1)) : ex_daddr;
	assign dmem_wdata = clr_busy_q ? 32'd0 : ldd_fire ? word_s1 : b;
	assign dmem_raddr = ex_daddr;

	msc_ram #(
		.WORDS (DMEM_WORDS)
	) u_dmem (
		.clk   (clk),
		.we    (dmem_we),
		.waddr (dmem_waddr),
		.wdata (dmem_wdata),
		.re    (exec_fire && ex.is_lw),
		.raddr (dmem_raddr),
		.rdata (dmem_rdata)
	);

	// Advance PC and pending load flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			lw_pend_q <= 1'b0;
		end else begin
			lw_pend_q <= exec_fire && ex.is_lw;
			if (exec_fire) begin
				pc_q <= ex.next_pc;
			end
		end
	end

	// Output register: load when executing, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (exec_fire) begin
			v_s2 <= 1'b1;
		end else if (m_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			epc_s2   <= pc_q;
			npc_s2   <= ex.next_pc;
			inv_s2   <= !ex.valid;
			rwe_s2   <= ex.wreg;
			rnum_s2  <= ex.dst;
			rval_s2  <= ex.value;
			lw_s2    <= ex.is_lw;
			mwe_s2   <= ex.wmem;
			maddr_s2 <= ex.wmem ? 8'(32'(ex_daddr)) : 8'd0;
			mval_s2  <= ex.wmem ? b : 32'd0;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {mval_s2, maddr_s2, mwe_s2,
	                   (lw_s2 ? dmem_rdata : rval_s2),
	                   rnum_s2, rwe_s2, inv_s2, npc_s2, epc_s2};

endmodule
